/* sv/afsg_pkg.sv */
// Package for the adaptive frame skip governor.
// Holds field widths, register indexes, action codes and the minimum skip count.
// No dependencies.
package afsg_pkg;

  localparam int NOW_W    = 32;
  localparam int SAMPLE_W = 24;
  localparam int SKIP_W   = 8;
  localparam int ACTION_W = 3;
  localparam int AVG_W    = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SKIP_MIN = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CONFIG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FPS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVAL_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_INTERVAL = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_IDLE     = 3'd0,
    ACT_STATIC   = 3'd1,
    ACT_INCREASE = 3'd2,
    ACT_DECREASE = 3'd3,
    ACT_HOLD     = 3'd4,
    ACT_STABLE   = 3'd5
  } afsg_action_t;

endpackage

/* sv/afsg_in_if.sv */
// Input request channel of the adaptive frame skip governor.
// Depends on afsg_pkg for the field widths.
interface afsg_in_if import afsg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [NOW_W-1:0]    now_ms;
  logic                has_sample;
  logic [SAMPLE_W-1:0] sample_us;

  modport source (output valid, output now_ms, output has_sample, output sample_us,
                  input ready);
  modport sink (input valid, input now_ms, input has_sample, input sample_us,
                output ready);
endinterface

/* sv/afsg_out_if.sv */
// Result request channel of the adaptive frame skip governor.
// Depends on afsg_pkg for the field widths.
interface afsg_out_if import afsg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SKIP_W-1:0]   skip_count;
  logic [ACTION_W-1:0] action;
  logic [AVG_W-1:0]    avg_time_q8;

  modport source (output valid, output skip_count, output action, output avg_time_q8,
                  input ready);
  modport sink (input valid, input skip_count, input action, input avg_time_q8,
                output ready);
endinterface

/* sv/adaptive_frame_skip_governor.sv */
// Adaptive frame skip governor: running average of frame time and skip count control.
// A request moves through the stage registers s0, s1, s2 and s3, then the output register.
// Throughput: one request per cycle; each stage advances whenever the next one is free.
// The average update and the skip decision each read and write their state in the same stage.
// Reset (synchronous, active low) clears the pipeline, the state and restores the
// register defaults. Depends on afsg_pkg, afsg_in_if and afsg_out_if.
module adaptive_frame_skip_governor import afsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  afsg_in_if.sink               in_ch,
  afsg_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [36:0] RECIP_HI  = 37'd419431;
  localparam logic [44:0] RECIP_LO  = 45'd6710887;
  localparam logic [46:0] RECIP_DEN = 47'd9773437;
  localparam logic [26:0] Q_SAT_LIM = 27'd7171875;
  localparam logic signed [9:0] SKIP_MIN_S = 10'(SKIP_MIN);

  logic signed [8:0] skip_cfg_r;
  logic [15:0]       fps_r;
  logic [15:0]       eval_r;
  logic [15:0]       hold_r;

  logic [AVG_W-1:0]  avg_r;
  logic [SKIP_W-1:0] cur_skip_r;
  logic [NOW_W-1:0]  last_check_r;
  logic [NOW_W-1:0]  last_change_r;

  logic                v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic [NOW_W-1:0]    s0_now_r, s1_now_r, s2_now_r, s3_now_r;
  logic                s0_has_r;
  logic [SAMPLE_W-1:0] s0_sample_r;
  logic [AVG_W-1:0]    s1_avg_r, s2_avg_r, s3_avg_r;
  logic [47:0]         s2_prod_r;
  logic [8:0]          s3_q_r;

  logic [SKIP_W-1:0]   out_skip_r;
  afsg_action_t        out_action_r;
  logic [AVG_W-1:0]    out_avg_r;

  logic en0, en1, en2, en3, en_out;

  assign en_out = !out_valid_r || out_ch.ready;
  assign en3    = !v3_r || en_out;
  assign en2    = !v2_r || en3;
  assign en1    = !v1_r || en2;
  assign en0    = !v0_r || en1;

  assign in_ch.ready        = en0;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.skip_count  = out_skip_r;
  assign out_ch.action      = out_action_r;
  assign out_ch.avg_time_q8 = out_avg_r;

  logic [35:0] acc;
  logic [17:0] xh;
  logic [36:0] qh_prod;
  logic [13:0] qh;
  logic [17:0] rh_full;
  logic [21:0] y;
  logic [44:0] ql_prod;
  logic [AVG_W-1:0] avg_nxt;

  always_comb begin
    acc     = 36'(avg_r) * 36'd9 + {4'b0000, s0_sample_r, 8'h00} + 36'd5;
    xh      = acc[35:18];
    qh_prod = 37'(xh) * RECIP_HI;
    qh      = qh_prod[35:22];
    rh_full = xh - 18'(qh) * 18'd10;
    y       = {rh_full[3:0], acc[17:0]};
    ql_prod = 45'(y) * RECIP_LO;
    avg_nxt = s0_has_r ? {qh, ql_prod[43:26]} : avg_r;
  end

  logic [47:0] pc_sum;
  logic [26:0] pc;
  logic [22:0] x_den;
  logic [46:0] q_prod;
  logic [8:0]  q_sat;

  always_comb begin
    pc_sum = s2_prod_r + 48'(2 ** 21 - 1);
    pc     = pc_sum[47:21];
    x_den  = pc[22:0] + 23'd28124;
    q_prod = 47'(x_den) * RECIP_DEN;
    q_sat  = (pc > Q_SAT_LIM) ? 9'd256 : q_prod[46:38];
  end

  logic [SKIP_W-1:0] cur_nxt;
  logic [NOW_W-1:0]  check_nxt;
  logic [NOW_W-1:0]  change_nxt;
  logic [NOW_W-1:0]  el_check;
  logic [NOW_W-1:0]  el_stable;
  afsg_action_t      action_nxt;
  logic signed [9:0] target;
  logic signed [9:0] qm1;
  logic signed [9:0] cur_s;
  logic signed [9:0] dec_s;
  logic [15:0]       div5_prod;
  logic [7:0]        step;
  logic [SKIP_W-1:0] shown;

  always_comb begin
    cur_nxt    = cur_skip_r;
    check_nxt  = last_check_r;
    change_nxt = last_change_r;
    action_nxt = ACT_IDLE;
    qm1        = $signed({1'b0, s3_q_r}) - 10'sd1;
    cur_s      = $signed({2'b00, cur_skip_r});
    div5_prod  = 16'(cur_skip_r) * 16'd205;
    step       = {2'b00, div5_prod[15:10]};
    if (step == 8'd0) begin
      step = 8'd1;
    end
    if (({1'b0, s3_q_r, 8'h00}) > {2'b00, fps_r}) begin
      target = $signed({2'b00, fps_r[15:8]}) - 10'sd1;
    end else if (qm1 < SKIP_MIN_S) begin
      target = SKIP_MIN_S;
    end else begin
      target = qm1;
    end
    dec_s = cur_s - $signed({2'b00, step});
    if (dec_s < target) begin
      dec_s = target;
    end
    if (dec_s < SKIP_MIN_S) begin
      dec_s = SKIP_MIN_S;
    end
    if (last_check_r == '0 || last_change_r == '0) begin
      check_nxt  = s3_now_r;
      change_nxt = s3_now_r;
    end
    el_check  = s3_now_r - check_nxt;
    el_stable = s3_now_r - change_nxt;

    if (skip_cfg_r[8]) begin
      check_nxt  = last_check_r;
      change_nxt = last_change_r;
    end else if (skip_cfg_r != 9'sd0) begin
      check_nxt  = last_check_r;
      change_nxt = last_change_r;
      if (cur_skip_r != skip_cfg_r[7:0]) begin
        cur_nxt    = skip_cfg_r[7:0];
        action_nxt = ACT_STATIC;
      end
    end else if (el_check > {16'h0000, eval_r}) begin
      check_nxt = s3_now_r;
      if (s3_avg_r != '0 && fps_r != '0) begin
        if (cur_s < target) begin
          cur_nxt    = target[7:0];
          change_nxt = s3_now_r;
          action_nxt = ACT_INCREASE;
        end else if (cur_s > target) begin
          if (el_stable > {16'h0000, hold_r}) begin
            cur_nxt    = dec_s[7:0];
            change_nxt = s3_now_r;
            action_nxt = ACT_DECREASE;
          end else begin
            action_nxt = ACT_HOLD;
          end
        end else begin
          action_nxt = ACT_STABLE;
        end
      end
    end
    shown = skip_cfg_r[8] ? '0 : cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_cfg_r    <= 9'sd0;
      fps_r         <= 16'd7680;
      eval_r        <= 16'd1000;
      hold_r        <= 16'd5000;
      avg_r         <= '0;
      cur_skip_r    <= '0;
      last_check_r  <= '0;
      last_change_r <= '0;
      v0_r          <= 1'b0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      v3_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SKIP_CONFIG:   skip_cfg_r <= $signed(cfg_wdata[8:0]);
          CFG_OUTPUT_FPS:    fps_r      <= cfg_wdata;
          CFG_EVAL_INTERVAL: eval_r     <= cfg_wdata;
          CFG_HOLD_INTERVAL: hold_r     <= cfg_wdata;
        endcase
      end
      if (en0) begin
        v0_r <= in_ch.valid;
      end
      if (en1) begin
        v1_r <= v0_r;
        if (v0_r) begin
          avg_r <= avg_nxt;
        end
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en_out) begin
        out_valid_r <= v3_r;
        if (v3_r) begin
          cur_skip_r    <= cur_nxt;
          last_check_r  <= check_nxt;
          last_change_r <= change_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s0_now_r    <= in_ch.now_ms;
      s0_has_r    <= in_ch.has_sample;
      s0_sample_r <= in_ch.sample_us;
    end
    if (en1) begin
      s1_now_r <= s0_now_r;
      s1_avg_r <= avg_nxt;
    end
    if (en2) begin
      s2_now_r  <= s1_now_r;
      s2_avg_r  <= s1_avg_r;
      s2_prod_r <= 48'(s1_avg_r) * 48'(fps_r);
    end
    if (en3) begin
      s3_now_r <= s2_now_r;
      s3_avg_r <= s2_avg_r;
      s3_q_r   <= q_sat;
    end
    if (en_out) begin
      out_skip_r   <= shown;
      out_action_r <= action_nxt;
      out_avg_r    <= s3_avg_r;
    end
  end

endmodule

/* bench/adaptive_frame_skip_governor_tb.sv */
// Self-checking testbench for the adaptive frame skip governor.
// A scoreboard class predicts every result from accepted requests; tasks drive
// the request and register ports. Depends on afsg_pkg, afsg_in_if and afsg_out_if.
`timescale 1ns / 100ps

module adaptive_frame_skip_governor_tb import afsg_pkg::*; ();

  localparam logic [63:0] FRAME_DEN   = 64'd58982400000;
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          SETTLE      = 10;

  typedef struct packed {
    logic [SKIP_W-1:0] skip;
    afsg_action_t      act;
    logic [AVG_W-1:0]  avg;
  } skip_result_t;

  class skip_tracker;
    logic [8:0]        skip_cfg;
    logic [15:0]       fps_q8;
    logic [15:0]       eval_ms;
    logic [15:0]       hold_ms;
    logic [AVG_W-1:0]  avg_q8;
    logic [SKIP_W-1:0] cur_skip;
    logic [31:0]       last_check;
    logic [31:0]       last_change;
    skip_result_t      expected_skips[$];
    int                errors;

    function void restart();
      skip_cfg    = 9'd0;
      fps_q8      = 16'd7680;
      eval_ms     = 16'd1000;
      hold_ms     = 16'd5000;
      avg_q8      = '0;
      cur_skip    = '0;
      last_check  = '0;
      last_change = '0;
      errors      = 0;
      expected_skips.delete();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SKIP_CONFIG:   skip_cfg = val[8:0];
        CFG_OUTPUT_FPS:    fps_q8   = val;
        CFG_EVAL_INTERVAL: eval_ms  = val;
        CFG_HOLD_INTERVAL: hold_ms  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_skips.size();
    endfunction

    function afsg_action_t auto_skip(logic [31:0] now_ms);
      logic [31:0] el_check;
      logic [31:0] el_stable;
      logic [63:0] num;
      longint      fps_l;
      longint      tgt;
      longint      cur;
      longint      step;
      longint      nxt;
      if (last_check == 0 || last_change == 0) begin
        last_check  = now_ms;
        last_change = now_ms;
      end
      el_check  = now_ms - last_check;
      el_stable = now_ms - last_change;
      if (el_check <= {16'd0, eval_ms}) return ACT_IDLE;
      last_check = now_ms;
      if (avg_q8 == 0 || fps_q8 == 0) return ACT_IDLE;
      num   = {48'd0, fps_q8} * {32'd0, avg_q8};
      fps_l = longint'(fps_q8);
      tgt   = longint'((num + FRAME_DEN - 64'd1) / FRAME_DEN) - 1;
      if ((tgt + 1) * 256 > fps_l) begin
        tgt = fps_l / 256 - 1;
      end else if (tgt < SKIP_MIN) begin
        tgt = SKIP_MIN;
      end
      cur = longint'(cur_skip);
      if (cur < tgt) begin
        cur_skip    = tgt[7:0];
        last_change = now_ms;
        return ACT_INCREASE;
      end
      if (cur > tgt) begin
        if (el_stable > {16'd0, hold_ms}) begin
          step = cur / 5;
          if (step < 1) step = 1;
          nxt = cur - step;
          if (nxt < tgt) nxt = tgt;
          if (nxt < SKIP_MIN) nxt = SKIP_MIN;
          cur_skip    = nxt[7:0];
          last_change = now_ms;
          return ACT_DECREASE;
        end
        return ACT_HOLD;
      end
      return ACT_STABLE;
    endfunction

    function void note_event(logic [NOW_W-1:0] now_ms, logic has_sample,
                             logic [SAMPLE_W-1:0] sample_us);
      logic [63:0]       acc;
      logic signed [8:0] mode;
      skip_result_t      res;
      if (has_sample) begin
        acc = {32'd0, avg_q8} * 64'd9 + ({40'd0, sample_us} << 8) + 64'd5;
        acc = acc / 64'd10;
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        avg_q8 = acc[31:0];
      end
      mode    = skip_cfg;
      res.act = ACT_IDLE;
      if (mode < 0) begin
        res.skip = '0;
      end else if (mode > 0) begin
        if ({1'b0, cur_skip} != skip_cfg) begin
          cur_skip = skip_cfg[7:0];
          res.act  = ACT_STATIC;
        end
        res.skip = cur_skip;
      end else begin
        res.act  = auto_skip(now_ms);
        res.skip = cur_skip;
      end
      res.avg = avg_q8;
      expected_skips = {expected_skips, res};
    endfunction

    function void check_result(logic [SKIP_W-1:0] skip, logic [ACTION_W-1:0] act,
                               logic [AVG_W-1:0] avg);
      skip_result_t want;
      if (expected_skips.size() == 0) begin
        $display("%0t: result without request: skip_count %0d action %0d avg_time_q8 %0d",
                 $time, skip, act, avg);
        errors++;
        return;
      end
      want = expected_skips.pop_front();
      if (skip !== want.skip) begin
        $display("%0t: skip_count expected %0d actual %0d", $time, want.skip, skip);
        errors++;
      end
      if (act !== want.act) begin
        $display("%0t: action expected %0d actual %0d", $time, want.act, act);
        errors++;
      end
      if (avg !== want.avg) begin
        $display("%0t: avg_time_q8 expected %0d actual %0d", $time, want.avg, avg);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  afsg_in_if  in_ch ();
  afsg_out_if out_ch ();

  adaptive_frame_skip_governor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  skip_tracker book;
  bit          steady;
  bit          long_hold_due;
  logic [31:0] clock_ms;
  int          load_us;
  int          cycle_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function int send_gap();
    if (steady || $urandom_range(0, 99) < 60) return 0;
    return pick_gap();
  endfunction

  task automatic send_event(input logic [NOW_W-1:0] now_ms, input logic has_sample,
                            input logic [SAMPLE_W-1:0] sample_us);
    int gap;
    gap = send_gap();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.now_ms     <= now_ms;
    in_ch.has_sample <= has_sample;
    in_ch.sample_us  <= sample_us;
    do @(posedge clk); while (!in_ch.ready);
    book.note_event(now_ms, has_sample, sample_us);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    book.set_reg(idx, val);
  endtask

  task automatic run_phase(input logic [8:0] mode, input logic [15:0] fps,
                           input logic [15:0] eval, input logic [15:0] hold,
                           input int count, input int step_max, input logic [31:0] start_ms,
                           input bit calm, input int pause_at, input bit long_hold);
    int                  r;
    logic [NOW_W-1:0]    now_ms;
    logic                has_sample;
    logic [SAMPLE_W-1:0] sample_us;
    wait_idle();
    write_reg(CFG_SKIP_CONFIG, {7'd0, mode});
    write_reg(CFG_OUTPUT_FPS, fps);
    write_reg(CFG_EVAL_INTERVAL, eval);
    write_reg(CFG_HOLD_INTERVAL, hold);
    @(negedge clk);
    cfg_we <= 1'b0;
    steady = calm;
    if (start_ms != 0) clock_ms = start_ms;
    if (long_hold) long_hold_due = 1'b1;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
      end
      if (i % 25 == 0) begin
        r = $urandom_range(0, 2);
        if (r == 0) load_us = $urandom_range(1000, 50000);
        else if (r == 1) load_us = $urandom_range(100000, 600000);
        else load_us = $urandom_range(600000, 2000000);
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        now_ms = '0;
      end else if (r < 6) begin
        now_ms = $urandom;
      end else begin
        clock_ms = clock_ms + $urandom_range(0, step_max);
        now_ms   = clock_ms;
      end
      has_sample = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 8 || !has_sample) begin
        sample_us = 24'($urandom);
      end else begin
        sample_us = 24'(load_us + $urandom_range(0, load_us / 4));
      end
      send_event(now_ms, has_sample, sample_us);
    end
  endtask

  task automatic random_phase(input int count);
    int          r;
    logic [8:0]  mode;
    logic [15:0] fps;
    logic [15:0] eval;
    logic [15:0] hold;
    r = $urandom_range(0, 99);
    if (r < 60) mode = 9'd0;
    else if (r < 80) mode = 9'($urandom_range(1, 254));
    else mode = 9'h1FF;
    if ($urandom_range(0, 1) == 0) fps = 16'($urandom_range(256, 15360));
    else fps = 16'($urandom_range(0, 65535));
    eval = 16'($urandom_range(0, 200));
    hold = 16'($urandom_range(0, 1000));
    run_phase(mode, fps, eval, hold, count, 2 * eval + 10, 32'd0, $urandom_range(0, 3) == 0,
              -1, 1'b0);
  endtask

  initial begin
    int gap_left;
    int hold_left;
    gap_left      = 0;
    hold_left     = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left     = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 20) gap_left = pick_gap();
      end
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        book.check_result(out_ch.skip_count, out_ch.action, out_ch.avg_time_q8);
      end
    end
  end

  initial begin
    book = new;
    book.restart();
    steady           = 1'b0;
    long_hold_due    = 1'b0;
    clock_ms         = 32'd0;
    load_us          = 10000;
    cycle_count      = 0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.now_ms     = '0;
    in_ch.has_sample = 1'b0;
    in_ch.sample_us  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register defaults after reset: automatic mode at 30 frames per second.
    send_event(32'd0, 1'b0, 24'd0);
    send_event(32'd100, 1'b1, 24'd0);
    send_event(32'd1200, 1'b1, 24'hFFFFFF);
    send_event(32'd1700, 1'b1, 24'hFFFFFF);
    send_event(32'd2300, 1'b1, 24'd0);
    send_event(32'd3400, 1'b1, 24'd0);
    send_event(32'd4500, 1'b1, 24'd0);
    send_event(32'd5600, 1'b1, 24'd0);
    send_event(32'd6700, 1'b1, 24'd0);
    send_event(32'd7800, 1'b0, 24'h5A5A5A);
    send_event(32'd8900, 1'b1, 24'd0);
    send_event(32'd10000, 1'b1, 24'd0);
    send_event(32'd11100, 1'b1, 24'd0);
    send_event(32'd12200, 1'b1, 24'd1);
    send_event(32'd13300, 1'b1, 24'd0);
    send_event(32'd19000, 1'b1, 24'd0);
    send_event(32'hFFFF_FC00, 1'b1, 24'd500000);
    send_event(32'hFFFF_FFFF, 1'b1, 24'd500000);
    send_event(32'h0000_0200, 1'b1, 24'd500000);
    send_event(32'h0000_0700, 1'b1, 24'd20000);
    send_event(32'h0000_1800, 1'b1, 24'hA5A5A5);
    clock_ms = 32'h0000_1800;

    run_phase(9'd0, 16'd7680, 16'd20, 16'd100, 150, 40, 32'd0, 1'b0, 75, 1'b0);
    run_phase(9'd1, 16'd7680, 16'd20, 16'd100, 40, 40, 32'd0, 1'b1, -1, 1'b0);
    run_phase(9'd254, 16'd65535, 16'd0, 16'd0, 40, 5, 32'd0, 1'b0, -1, 1'b0);
    run_phase(9'd0, 16'd65535, 16'd0, 16'd0, 150, 5, 32'd0, 1'b0, -1, 1'b1);
    run_phase(9'h1FF, 16'd7680, 16'd0, 16'd0, 40, 5, 32'd0, 1'b0, -1, 1'b0);
    run_phase(9'd0, 16'd0, 16'd0, 16'd0, 40, 5, 32'd0, 1'b0, -1, 1'b0);
    run_phase(9'd0, 16'd100, 16'd5, 16'd10, 60, 12, 32'd0, 1'b0, -1, 1'b0);
    run_phase(9'd0, 16'd300, 16'd5, 16'd10, 60, 12, 32'd0, 1'b1, -1, 1'b0);
    run_phase(9'd0, 16'd65535, 16'd65535, 16'd65535, 60, 70000, 32'hFFF0_0000, 1'b0, -1,
              1'b0);
    run_phase(9'd5, 16'd1000, 16'd0, 16'd0, 30, 5, 32'd0, 1'b0, -1, 1'b0);
    run_phase(9'd0, 16'd7680, 16'd1000, 16'd5000, 120, 3000, 32'd0, 1'b0, -1, 1'b0);
    repeat (3) random_phase(80);

    wait_idle();
    if (book.errors == 0 && book.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
